### hdl/mkspn_pkg.sv
// Shared constants and types for the makespan estimator.
package mkspn_pkg;

	localparam int AGENTS    = 64;
	localparam int AGENT_W   = 6;
	localparam int TIME_W    = 32;
	localparam int AGENT_AW  = (AGENTS > 1) ? $clog2(AGENTS) : 1;
	localparam int IN_DATA_W = 40;

	typedef logic [AGENT_W-1:0]  agent_t;
	typedef logic [TIME_W-1:0]   time_t;
	typedef logic [AGENT_AW-1:0] load_addr_t;

	localparam time_t TIME_MAX = '1;

endpackage

### hdl/mkspn_load_ram.sv
// Agent load memory: one write port, one registered read port.
module mkspn_load_ram
	import mkspn_pkg::*;
(
	input  logic       clk,
	input  logic       rd_en,
	input  load_addr_t rd_addr,
	output time_t      rd_data,
	input  logic       wr_en,
	input  load_addr_t wr_addr,
	input  time_t      wr_data
);

	time_t mem [AGENTS];
	time_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### hdl/makespan_estimator_core.sv
// Makespan estimator top level: load update pipeline, running maximum, result register.
//
// Each request is one task: its agent's load is read from a 64-entry memory, the task
// time is added with saturation at the top of the Q16.16 range, and the sum is written
// back while a running maximum of all loads is kept. One task is taken per clock unless
// input is held off; the single read port of the load memory sets that rate, and a task
// on the same agent as the one just before it takes the freshly written sum through a
// bypass. The result for a task marked last is registered on the output when that task
// leaves the first stage, and all loads are cleared at once by per-agent valid bits, so
// the next assignment may follow directly with no clearing pass. Input is held off only
// while a finished result waits and a further last task arrives.
module makespan_estimator_core
	import mkspn_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [IN_DATA_W-1:0] s_axis_tdata,   // agent[5:0], task_time[37:6], zero pad
	input  logic                 s_axis_tlast,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [TIME_W-1:0]    m_axis_tdata,   // makespan[31:0]
	output logic                 m_axis_tuser    // saturated
);

	logic       vld_s1;
	agent_t     agent_s1;
	time_t      time_s1;
	logic       last_s1;

	logic       fwd_vld_q;
	load_addr_t fwd_addr_q;
	time_t      fwd_data_q;

	logic [AGENTS-1:0] ld_vld_q;
	time_t      run_max_q;
	logic       ovf_q;

	logic       out_vld_q;
	time_t      out_data_q;
	logic       out_sat_q;

	logic       in_fire;
	logic       s1_fire;
	logic       s1_stall;
	agent_t     in_agent;
	time_t      in_time;
	load_addr_t rd_addr;
	time_t      rd_data;
	load_addr_t addr_s1;
	logic       in_range;
	time_t      old_load;
	logic [TIME_W:0] sum_wide;
	logic       sat_now;
	time_t      new_load;
	time_t      max_next;
	logic       ovf_next;

	assign in_agent = s_axis_tdata[AGENT_W-1:0];
	assign in_time  = s_axis_tdata[AGENT_W+TIME_W-1:AGENT_W];
	assign rd_addr  = AGENT_AW'(in_agent);

	assign s1_stall      = vld_s1 && last_s1 && out_vld_q && !m_axis_tready;
	assign s1_fire       = vld_s1 && !s1_stall;
	assign s_axis_tready = !vld_s1 || s1_fire;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	mkspn_load_ram u_load_ram (
		.clk     (clk),
		.rd_en   (in_fire),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (s1_fire && in_range),
		.wr_addr (addr_s1),
		.wr_data (new_load)
	);

	assign addr_s1  = AGENT_AW'(agent_s1);
	assign in_range = 32'(agent_s1) < 32'(AGENTS);

	always_comb begin
		if (fwd_vld_q && (fwd_addr_q == addr_s1)) begin
			old_load = fwd_data_q;
		end else if (ld_vld_q[addr_s1]) begin
			old_load = rd_data;
		end else begin
			old_load = '0;
		end
		sum_wide = {1'b0, old_load} + {1'b0, time_s1};
		sat_now  = in_range && sum_wide[TIME_W];
		new_load = sum_wide[TIME_W] ? TIME_MAX : sum_wide[TIME_W-1:0];
		max_next = (in_range && (new_load > run_max_q)) ? new_load : run_max_q;
		ovf_next = ovf_q || sat_now;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			agent_s1 <= in_agent;
			time_s1  <= in_time;
			last_s1  <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_vld_q <= 1'b0;
			ld_vld_q  <= '0;
			run_max_q <= '0;
			ovf_q     <= 1'b0;
		end else if (s1_fire) begin
			if (last_s1) begin
				fwd_vld_q <= 1'b0;
				ld_vld_q  <= '0;
				run_max_q <= '0;
				ovf_q     <= 1'b0;
			end else begin
				fwd_vld_q <= in_range;
				if (in_range) begin
					ld_vld_q[addr_s1] <= 1'b1;
				end
				run_max_q <= max_next;
				ovf_q     <= ovf_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && in_range) begin
			fwd_addr_q <= addr_s1;
			fwd_data_q <= new_load;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (s1_fire && last_s1) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && last_s1) begin
			out_data_q <= max_next;
			out_sat_q  <= ovf_next;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_sat_q;

endmodule
